/* rtl/dfs_pkg.sv */
// dfs_pkg: shared types for the delimited field splitter
// no dependencies; imported by the front, queue, back and top level
`default_nettype none

package dfs_pkg;

   // one queue entry: every result that a single request produces
   typedef struct packed {
      logic        sep_vld;    // a field closed by a separator
      logic [15:0] sep_start;
      logic [15:0] sep_len;
      logic        eol;        // the final field of the line
      logic [15:0] fin_start;
      logic [15:0] fin_len;
      logic        ovf;
   } dfs_entry_type;

   localparam int unsigned CsrIdxBits = 2;

   typedef enum logic [CsrIdxBits-1:0] {
      CSR_SEP_BYTES = 2'd0,
      CSR_SEP_LEN   = 2'd1,
      CSR_ESC_BYTE  = 2'd2
   } dfs_csr_type;

endpackage

`default_nettype wire

/* rtl/dfs_front.sv */
// dfs_front: accepts bytes, tracks line state and detects separators
// depends on dfs_pkg; pushes one entry per request that yields results
`default_nettype none

module dfs_front
   import dfs_pkg::*;
#(
   parameter int MAX_SEPARATOR_BYTES = 8,
   parameter int POSITION_BITS       = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic                req_has_byte,
   input  wire logic                req_end_of_line,
   input  wire logic [63:0]         sep_bytes,
   input  wire logic [3:0]          sep_length,
   input  wire logic [7:0]          esc_byte,
   input  wire logic                q_ready,
   output      logic                q_push,
   output      dfs_entry_type       q_entry
);

   localparam int PW = POSITION_BITS;
   localparam int MS = MAX_SEPARATOR_BYTES;
   localparam logic [PW-1:0] POS_MAX = '1;
   localparam logic [3:0]    MS_4    = 4'(MS);

   function automatic logic [15:0] sat16(input logic [PW-1:0] v);
      logic [32:0] w;
      w = 33'(v);
      sat16 = (w > 33'd65535) ? 16'hFFFF : w[15:0];
   endfunction

   function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
      sat_inc = (v == POS_MAX) ? v : v + PW'(1);
   endfunction

   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] fbeg_ff, fbeg_in;
   logic [PW-1:0] blk_ff, blk_in;
   logic          ovf_ff, ovf_in;
   logic [7:0]    hist_ff [MS];
   logic [7:0]    hist_in [MS];

   logic [7:0]    win [MS+1];
   logic [MS:1]   match_len;
   logic [MS:1]   esc_at;
   logic [3:0]    len_eff;
   logic          hit_raw, esc_seen, pos_ok, hit, accept;
   logic [PW:0]   end_ext;
   logic [PW-1:0] sep_s, sep_len, fin_len, pos_nxt, fbeg_nxt;

   assign req_ready = q_ready;
   assign accept    = req_valid && req_ready;

   // separator window: newest byte first
   always_comb begin
      win[0] = req_data_byte;
      for (int j = 1; j <= MS; j++) begin
         win[j] = hist_ff[j-1];
      end
      for (int l = 1; l <= MS; l++) begin
         match_len[l] = 1'b1;
         for (int k = 0; k < l; k++) begin
            if (win[l-1-k] != sep_bytes[8*k +: 8]) begin
               match_len[l] = 1'b0;
            end
         end
         esc_at[l] = (win[l] == esc_byte);
      end
   end

   always_comb begin
      len_eff  = (sep_length > MS_4) ? MS_4 : sep_length;
      hit_raw  = 1'b0;
      esc_seen = 1'b0;
      for (int l = 1; l <= MS; l++) begin
         if (len_eff == 4'(l)) begin
            hit_raw  = match_len[l];
            esc_seen = esc_at[l];
         end
      end
      end_ext = {1'b0, pos_ff} + (PW+1)'(1);
      pos_ok  = (len_eff != 4'd0) && (end_ext >= (PW+1)'(len_eff));
      sep_s   = PW'(end_ext - (PW+1)'(len_eff));
      hit     = req_has_byte && pos_ok && hit_raw
              && !((esc_byte != 8'd0) && (sep_s != '0) && esc_seen)
              && (sep_s >= blk_ff);
      sep_len = (sep_s >= fbeg_ff) ? sep_s - fbeg_ff : '0;

      pos_nxt  = req_has_byte ? sat_inc(pos_ff) : pos_ff;
      fbeg_nxt = hit ? sat_inc(pos_ff) : fbeg_ff;
      fin_len  = (pos_nxt >= fbeg_nxt) ? pos_nxt - fbeg_nxt : '0;
   end

   always_comb begin
      ovf_in  = ovf_ff;
      pos_in  = pos_ff;
      fbeg_in = fbeg_ff;
      blk_in  = blk_ff;
      hist_in = hist_ff;
      if (accept) begin
         ovf_in  = ovf_ff || (req_has_byte && (pos_ff == POS_MAX));
         pos_in  = pos_nxt;
         fbeg_in = fbeg_nxt;
         blk_in  = hit ? fbeg_nxt : blk_ff;
         if (req_has_byte) begin
            hist_in[0] = req_data_byte;
            for (int j = 1; j < MS; j++) begin
               hist_in[j] = hist_ff[j-1];
            end
         end
         if (req_end_of_line) begin
            ovf_in  = 1'b0;
            pos_in  = '0;
            fbeg_in = '0;
            blk_in  = '0;
            for (int j = 0; j < MS; j++) begin
               hist_in[j] = 8'd0;
            end
         end
      end
   end

   always_comb begin
      q_push            = accept && (hit || req_end_of_line);
      q_entry.sep_vld   = hit;
      q_entry.sep_start = sat16(fbeg_ff);
      q_entry.sep_len   = sat16(sep_len);
      q_entry.eol       = req_end_of_line;
      q_entry.fin_start = sat16(fbeg_nxt);
      q_entry.fin_len   = sat16(fin_len);
      q_entry.ovf       = ovf_ff || (req_has_byte && (pos_ff == POS_MAX));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_ff  <= 1'b0;
         pos_ff  <= '0;
         fbeg_ff <= '0;
         blk_ff  <= '0;
         for (int j = 0; j < MS; j++) begin
            hist_ff[j] <= 8'd0;
         end
      end else begin
         ovf_ff  <= ovf_in;
         pos_ff  <= pos_in;
         fbeg_ff <= fbeg_in;
         blk_ff  <= blk_in;
         hist_ff <= hist_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/dfs_queue.sv */
// dfs_queue: two-entry queue between the front and back parts
// depends on dfs_pkg for the entry type
`default_nettype none

module dfs_queue
   import dfs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire dfs_entry_type push_entry,
   output      logic          not_full,
   input  wire logic          pop,
   output      logic          not_empty,
   output      dfs_entry_type head
);

   localparam int Depth = 2;

   dfs_entry_type slot_ff [Depth];
   logic          wptr_ff, wptr_in;
   logic          rptr_ff, rptr_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign not_full  = (cnt_ff != 2'(Depth));
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = slot_ff[rptr_ff];
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wptr_in = do_push ? ~wptr_ff : wptr_ff;
      rptr_in = do_pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* rtl/dfs_back.sv */
// dfs_back: unpacks queue entries into one response per cycle while
// rsp_ready is high; depends on dfs_pkg for the entry type
`default_nettype none

module dfs_back
   import dfs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  wire dfs_entry_type q_head,
   output      logic          q_pop,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   output      logic [15:0]   rsp_field_start,
   output      logic [15:0]   rsp_field_length,
   output      logic          rsp_last_field,
   output      logic          rsp_overflow
);

   dfs_entry_type cur_ff, cur_in;
   logic          sep_pend_ff, sep_pend_in;
   logic          fin_pend_ff, fin_pend_in;
   logic          fire, done;

   assign rsp_valid        = sep_pend_ff || fin_pend_ff;
   assign rsp_field_start  = sep_pend_ff ? cur_ff.sep_start : cur_ff.fin_start;
   assign rsp_field_length = sep_pend_ff ? cur_ff.sep_len : cur_ff.fin_len;
   assign rsp_last_field   = !sep_pend_ff;
   assign rsp_overflow     = cur_ff.ovf;

   assign fire  = rsp_valid && rsp_ready;
   // slot frees when empty or its last pending response leaves now
   assign done  = !rsp_valid || (fire && !(sep_pend_ff && fin_pend_ff));
   assign q_pop = done && q_valid;

   always_comb begin
      cur_in      = cur_ff;
      sep_pend_in = sep_pend_ff;
      fin_pend_in = fin_pend_ff;
      if (q_pop) begin
         cur_in      = q_head;
         sep_pend_in = q_head.sep_vld;
         fin_pend_in = q_head.eol;
      end else if (fire) begin
         if (sep_pend_ff) begin
            sep_pend_in = 1'b0;
         end else begin
            fin_pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_pend_ff <= 1'b0;
         fin_pend_ff <= 1'b0;
      end else begin
         sep_pend_ff <= sep_pend_in;
         fin_pend_ff <= fin_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

`default_nettype wire

/* rtl/delimited_field_splitter_unit.sv */
// delimited_field_splitter_unit: top level of the delimited field splitter
// depends on dfs_pkg, dfs_front, dfs_queue and dfs_back
//
// Usage: the req channel carries one byte of a text line per request
// (req_has_byte low for an empty line), req_end_of_line closes the line.
// The rsp channel returns the offset and length of each field; a request
// yields at most two responses, the field closed by a separator ending on
// its byte, then the final field when it closes the line.
// The csr port writes the separator bytes, separator length and escape byte
// with no wait; write it only while the block is idle.
// Throughput: one request per cycle while the queue has room; the separator
// compare runs on the whole window in parallel in the front stage. Responses
// leave at one per cycle while rsp_ready is high. Results are registered in
// the queue and then in the back stage before a request's first response.
// A two-entry queue parts front and back: when rsp_ready stalls, requests
// keep being taken until the queue fills, then req_ready drops.
// Reset clears line state and queue; registers return to separator 0x01,
// length 1 and escape check off.
`default_nettype none

module delimited_field_splitter_unit
   import dfs_pkg::*;
#(
   parameter int MAX_SEPARATOR_BYTES = 8,
   parameter int POSITION_BITS       = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_has_byte,
   input  wire logic                  req_end_of_line,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [15:0]           rsp_field_start,
   output      logic [15:0]           rsp_field_length,
   output      logic                  rsp_last_field,
   output      logic                  rsp_overflow,
   input  wire logic                  csr_write_en,
   input  wire logic [CsrIdxBits-1:0] csr_index,
   input  wire logic [63:0]           csr_wdata
);

   logic [63:0]   sep_bytes_ff, sep_bytes_in;
   logic [3:0]    sep_len_ff, sep_len_in;
   logic [7:0]    esc_ff, esc_in;
   logic          q_ready, q_push, q_valid, q_pop;
   dfs_entry_type q_entry, q_head;

   always_comb begin
      sep_bytes_in = sep_bytes_ff;
      sep_len_in   = sep_len_ff;
      esc_in       = esc_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_SEP_BYTES: sep_bytes_in = csr_wdata;
            CSR_SEP_LEN:   sep_len_in   = csr_wdata[3:0];
            CSR_ESC_BYTE:  esc_in       = csr_wdata[7:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_bytes_ff <= 64'd1;
         sep_len_ff   <= 4'd1;
         esc_ff       <= 8'd0;
      end else begin
         sep_bytes_ff <= sep_bytes_in;
         sep_len_ff   <= sep_len_in;
         esc_ff       <= esc_in;
      end
   end

   dfs_front #(
      .MAX_SEPARATOR_BYTES (MAX_SEPARATOR_BYTES),
      .POSITION_BITS       (POSITION_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_has_byte    (req_has_byte),
      .req_end_of_line (req_end_of_line),
      .sep_bytes       (sep_bytes_ff),
      .sep_length      (sep_len_ff),
      .esc_byte        (esc_ff),
      .q_ready         (q_ready),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   dfs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .not_full   (q_ready),
      .pop        (q_pop),
      .not_empty  (q_valid),
      .head       (q_head)
   );

   dfs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_field_start  (rsp_field_start),
      .rsp_field_length (rsp_field_length),
      .rsp_last_field   (rsp_last_field),
      .rsp_overflow     (rsp_overflow)
   );

endmodule

`default_nettype wire

/* rtl/dfs_checker.sv */
// dfs_checker: port-level assertions for the delimited field splitter
// bound to delimited_field_splitter_unit; no other dependencies
`default_nettype none

module dfs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        req_end_of_line,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_field_start,
   input wire logic [15:0] rsp_field_length,
   input wire logic        rsp_last_field,
   input wire logic        rsp_overflow
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_field_start)
         && $stable(rsp_field_length) && $stable(rsp_last_field)
         && $stable(rsp_overflow))
      else $error("response changed while stalled");

   // nothing is shown right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // requests are refused only when the response side holds something
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request refused with idle response side");

   // a closing request taken at an idle response side is shown once registered
   a_eol_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end_of_line && !rsp_valid |-> ##2 rsp_valid)
      else $error("final field not delivered in time");

endmodule

bind delimited_field_splitter_unit dfs_checker u_dfs_checker (.*);

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// testbench: self-checking bench for delimited_field_splitter_unit
// depends on dfs_pkg and the splitter rtl; a field predictor scores every response

module testbench;
   import dfs_pkg::*;

   localparam int unsigned PosMax       = 65535;
   localparam int unsigned SepMax       = 8;
   localparam int unsigned IdleLimit    = 4000;
   localparam int unsigned SettleCycles = 8;
   localparam int unsigned HoldCycles   = 300;
   localparam int unsigned ReportCap    = 30;
   localparam logic [CsrIdxBits-1:0] CsrSpareIdx = 2'd3;

   typedef struct packed {
      logic [15:0] start;
      logic [15:0] length;
      logic        last;
      logic        ovf;
   } field_type;

   class field_split_board;
      logic [63:0] sep_bytes;
      logic [3:0]  sep_len;
      logic [7:0]  esc_byte;
      int unsigned line_pos;
      int unsigned field_begin;
      int unsigned blocked_until;
      logic        line_ovf;
      logic [7:0]  recent [SepMax+1];
      field_type   fields_due [$];
      int unsigned mismatches;
      int unsigned requests;
      int unsigned lines;
      int unsigned fields_seen;

      function new();
         set_registers(64'd1, 4'd1, 8'd0);
         clear_line();
         mismatches  = 0;
         requests    = 0;
         lines       = 0;
         fields_seen = 0;
      endfunction

      function void set_registers(logic [63:0] sep, logic [3:0] len, logic [7:0] esc);
         sep_bytes = sep;
         sep_len   = len;
         esc_byte  = esc;
      endfunction

      function void clear_line();
         line_pos      = 0;
         field_begin   = 0;
         blocked_until = 0;
         line_ovf      = 1'b0;
         foreach (recent[i]) recent[i] = 8'd0;
      endfunction

      function int unsigned sat_inc(int unsigned v);
         return (v >= PosMax) ? PosMax : v + 1;
      endfunction

      function void push_field(int unsigned start, int unsigned len, logic last);
         field_type f;
         f.start  = start[15:0];
         f.length = len[15:0];
         f.last   = last;
         f.ovf    = line_ovf;
         fields_due.insert(fields_due.size(), f);
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= ReportCap) $display("mismatch: %s", msg);
      endtask

      // predicts the fields closed by one accepted request
      function void note_request(logic [7:0] b, logic has, logic eol);
         int unsigned p;
         int unsigned lsep;
         int unsigned s;
         int unsigned k;
         bit          hit;
         requests++;
         if (has) begin
            p    = line_pos;
            lsep = (sep_len > SepMax) ? SepMax : sep_len;
            if (p >= PosMax) line_ovf = 1'b1;
            for (k = SepMax; k > 0; k--) recent[k] = recent[k-1];
            recent[0] = b;
            if (lsep > 0 && p + 1 >= lsep) begin
               s   = p + 1 - lsep;
               hit = 1'b1;
               for (k = 0; k < lsep; k++) begin
                  if (recent[lsep-1-k] != sep_bytes[8*k +: 8]) hit = 1'b0;
               end
               // escaped candidate is dropped and blocks nothing
               if (hit && esc_byte != 0 && s > 0 && recent[lsep] == esc_byte) hit = 1'b0;
               if (hit && s >= blocked_until) begin
                  push_field(field_begin, (s >= field_begin) ? s - field_begin : 0, 1'b0);
                  field_begin   = sat_inc(p);
                  blocked_until = field_begin;
               end
            end
            line_pos = sat_inc(p);
         end
         if (eol) begin
            push_field(field_begin,
                       (line_pos >= field_begin) ? line_pos - field_begin : 0, 1'b1);
            lines++;
            clear_line();
         end
      endfunction

      task check_field(field_type got);
         field_type want;
         fields_seen++;
         if (fields_due.size() == 0) begin
            report($sformatf("unexpected field start %0d len %0d", got.start, got.length));
         end else begin
            want = fields_due.pop_front();
            if (got !== want)
               report($sformatf("got start %0d len %0d last %b ovf %b, want %0d %0d %b %b",
                                got.start, got.length, got.last, got.ovf,
                                want.start, want.length, want.last, want.ovf));
         end
      endtask
   endclass

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_data_byte   = 8'd0;
   logic                  req_has_byte    = 1'b0;
   logic                  req_end_of_line = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic [15:0]           rsp_field_start;
   logic [15:0]           rsp_field_length;
   logic                  rsp_last_field;
   logic                  rsp_overflow;
   logic                  csr_write_en    = 1'b0;
   logic [CsrIdxBits-1:0] csr_index       = '0;
   logic [63:0]           csr_wdata       = '0;

   field_split_board sb = new();

   logic [63:0] cur_sep = 64'd1;
   logic [3:0]  cur_len = 4'd1;
   logic [7:0]  cur_esc = 8'd0;
   int unsigned burst_left = 0;
   int unsigned gap_max    = 4;
   int unsigned items_sent = 0;
   int unsigned settings   = 0;
   int unsigned idle_cycles = 0;
   int unsigned hold_left  = 0;
   int unsigned stall_pct  = 0;
   int unsigned stall_span = 0;
   logic        hold_go    = 1'b0;
   logic        hold_done  = 1'b0;

   delimited_field_splitter_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_has_byte     (req_has_byte),
      .req_end_of_line  (req_end_of_line),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_field_start  (rsp_field_start),
      .rsp_field_length (rsp_field_length),
      .rsp_last_field   (rsp_last_field),
      .rsp_overflow     (rsp_overflow),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   // both channels sampled at the edge, before any stimulus update lands
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data_byte, req_has_byte,
                                                      req_end_of_line);
         if (rsp_valid && rsp_ready)
            sb.check_field(field_type'({rsp_field_start, rsp_field_length,
                                        rsp_last_field, rsp_overflow}));
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IdleLimit) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // receiver: stall rate changes every so often, one long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HoldCycles;
         hold_done <= 1'b1;
      end else begin
         if (stall_span == 0) begin
            case ($urandom_range(0, 4))
               0, 1: stall_pct <= 0;
               2: stall_pct <= 25;
               3: stall_pct <= 50;
               default: stall_pct <= 90;
            endcase
            stall_span <= $urandom_range(20, 120);
         end else begin
            stall_span <= stall_span - 1;
         end
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_request(input logic [7:0] b, input logic has, input logic eol);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_has_byte    <= has;
      req_end_of_line <= eol;
      if (has || eol) items_sent++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid  <= 1'b0;
      burst_left = 0;
      // let the last accepted request reach the predictor first
      @(posedge clock);
      while (sb.fields_due.size() != 0) @(posedge clock);
      // idle requests cause no field, so give the pipeline time to empty
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_registers(input logic [63:0] sep, input logic [3:0] len,
                                  input logic [7:0] esc, input logic spare);
      logic [63:0] noise;
      wait_idle();
      noise = {$urandom, $urandom};
      csr_write_en <= 1'b1;
      csr_index    <= CSR_SEP_BYTES;
      csr_wdata    <= sep;
      @(posedge clock);
      csr_index    <= CSR_SEP_LEN;
      csr_wdata    <= {noise[63:4], len};
      @(posedge clock);
      csr_index    <= CSR_ESC_BYTE;
      csr_wdata    <= {noise[63:8], esc};
      @(posedge clock);
      if (spare) begin
         csr_index <= CsrSpareIdx;
         csr_wdata <= {$urandom, $urandom};
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      sb.set_registers(sep, len, esc);
      cur_sep = sep;
      cur_len = len;
      cur_esc = esc;
      settings++;
   endtask

   // line built from separators, escaped separators, cut separators and noise
   task automatic send_random_line(input int unsigned target);
      int unsigned k;
      int unsigned cnt;
      int unsigned len_gen;
      logic [7:0]  line_q [$];
      logic        end_on_byte;
      len_gen = (cur_len == 0) ? 2 : ((cur_len > SepMax) ? SepMax : cur_len);
      while (line_q.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               for (k = 0; k < len_gen; k++) line_q.insert(line_q.size(), cur_sep[8*k +: 8]);
            end
            3: begin
               line_q.insert(line_q.size(), cur_esc);
               for (k = 0; k < len_gen; k++) line_q.insert(line_q.size(), cur_sep[8*k +: 8]);
            end
            4: begin
               cnt = (len_gen > 1) ? $urandom_range(1, len_gen - 1) : 1;
               for (k = 0; k < cnt; k++) line_q.insert(line_q.size(), cur_sep[8*k +: 8]);
            end
            5: line_q.insert(line_q.size(), 8'($urandom_range(0, 255)));
            6: line_q.insert(line_q.size(), cur_esc);
            default: line_q.insert(line_q.size(),
                                   cur_sep[8*$urandom_range(0, len_gen - 1) +: 8]);
         endcase
      end
      end_on_byte = ($urandom_range(0, 3) != 0) && (line_q.size() != 0);
      for (k = 0; k < line_q.size(); k++) begin
         if ($urandom_range(0, 15) == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_request(line_q[k], 1'b1, end_on_byte && (k == line_q.size() - 1));
      end
      if (!end_on_byte) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   initial begin
      int unsigned phase;
      int unsigned stop_at;
      int unsigned n;
      logic [63:0] sep;
      logic [3:0]  len;
      logic [7:0]  esc;

      repeat (6) @(posedge clock);
      reset   <= 1'b0;
      gap_max = 6;

      // reset settings: single 0x01 separator, no escape
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_request(8'h01, 1'b1, 1'b0);
      send_request(8'hFF, 1'b1, 1'b0);
      send_request(8'h01, 1'b1, 1'b1);
      send_request(8'h00, 1'b1, 1'b1);

      // two-byte separator with escape, then a separator cut by end of line
      write_registers(64'hFFFF_FFFF_FFFF_6261, 4'd2, 8'h5C, 1'b1);
      send_request(8'h5C, 1'b1, 1'b0);
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h62, 1'b1, 1'b0);
      send_request(8'h61, 1'b1, 1'b0);
      send_request(8'h62, 1'b1, 1'b0);
      send_request(8'h61, 1'b1, 1'b1);

      // overlapping candidates: greedy, no overlap
      write_registers(64'h0000_0000_0000_6161, 4'd2, 8'h00, 1'b0);
      for (n = 0; n < 4; n++) send_request(8'h61, 1'b1, n == 3);

      // length above the maximum acts as eight, escape equal to separator byte
      write_registers({64{1'b1}}, 4'd15, 8'hFF, 1'b0);
      for (n = 0; n < 9; n++) send_request(8'hFF, 1'b1, n == 8);

      // length zero never splits
      write_registers(64'd1, 4'd0, 8'h00, 1'b0);
      send_request(8'h01, 1'b1, 1'b0);
      send_request(8'h01, 1'b1, 1'b1);

      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0: begin
               sep = 64'd0;
               len = 4'd1;
               esc = 8'd0;
            end
            1: begin
               sep = {64{1'b1}};
               len = 4'd8;
               esc = 8'hFF;
            end
            2: begin
               sep = {$urandom, $urandom};
               len = 4'd0;
               esc = 8'($urandom_range(1, 255));
            end
            3: begin
               sep = {$urandom, $urandom};
               len = 4'd15;
               esc = 8'($urandom_range(1, 255));
            end
            default: begin
               sep = {$urandom, $urandom};
               case ($urandom_range(0, 5))
                  0: len = 4'd1;
                  1: len = 4'd2;
                  2: len = 4'd3;
                  3: len = 4'($urandom_range(4, 8));
                  default: len = 4'($urandom_range(0, 15));
               endcase
               esc = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            end
         endcase
         gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         write_registers(sep, len, esc, 1'b0);
         // hold the response side while requests keep coming
         if (phase == 2) hold_go <= 1'b1;
         stop_at = items_sent + 140;
         while (items_sent < stop_at)
            send_random_line(($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                          : $urandom_range(0, 20));
      end

      gap_max = 3;
      send_random_line(12);

      wait_idle();
      $display("covered %0d requests in %0d lines, %0d fields compared",
               sb.requests, sb.lines, sb.fields_seen);
      $display("%0d register settings and one long hold-off on the response side",
               settings);
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
